// ===== rtl/rsft_pkg.sv =====
//==============================================================================
// rsft_pkg
// Shared widths, codes and controller/datapath interface types of the race
// start and finish timer.
//==============================================================================
`default_nettype none

package rsft_pkg;

   // Field widths of one time stamp: hour[26:22] min[21:16] sec[15:10] msec[9:0]
   localparam int TIME_W  = 27;
   localparam int MS_W    = 10;
   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;

   // Request and response field widths
   localparam int OP_W        = 2;
   localparam int BYTE_W      = 8;
   localparam int ENTRY_W     = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 88;

   // Request kinds carried on req_tuser
   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_BYTE   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   // Response kinds carried on rsp_tuser
   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_ENTRY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FIN_RD,
      ST_FIN_WR,
      ST_ACK,
      ST_DUMP_RD,
      ST_DUMP_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic req_load;
      logic tick;
      logic byte_done;
      logic stamp_start;
      logic clear_slot;
      logic fin_write;
      logic rd_en;
      logic rd_dump;
      logic idx_clear;
      logic idx_inc;
      logic emit_ack;
      logic emit_entry;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic                is_tick;
      logic                is_byte;
      logic                is_finish;
      logic                is_start_cmd;
      logic                is_ack_cmd;
      logic                is_read_cmd;
      logic                can_start;
      logic                can_finish;
      logic                clear_ok;
      logic                idx_last;
      logic                out_free;
      logic [ENTRY_W-1:0]  started;
      logic [ENTRY_W-1:0]  finished;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/race_start_finish_timer_unit.sv =====
//==============================================================================
// race_start_finish_timer_unit
// Start and finish timing recorder with a time-of-day clock and tables of
// start, finish and elapsed times.
//==============================================================================
//
//  Channel  Direction  Payload                                   Handshake
//  req_     in         tuser: op; tdata: rx_byte, subsec          tvalid/tready
//  rsp_     out        tuser: kind; tdata: entry, start, finish,  tvalid/tready
//                      elapsed; tlast: last
//
//  A tick or an ignored byte passes through ST_IDLE and ST_DECODE; an
//  acknowledged command adds ST_ACK, and a finish press adds ST_FIN_RD and
//  ST_FIN_WR. A read command walks the tables through their single read
//  port, with ST_DUMP_RD and ST_DUMP_EMIT for each slot.
//  Reset is synchronous; the tables read as zero right after reset through
//  per-slot valid flags, so there is no clearing pass.
//  A stalled response holds in the output register; the block keeps taking
//  requests that produce no response while it waits.
//
`default_nettype none

module race_start_finish_timer_unit import rsft_pkg::*; #(
   parameter int MAX_ENTRIES = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // rx_byte[7:0], subsec[17:8]
   input  wire logic [OP_W-1:0]        req_tuser,   // op[1:0]
   // Response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // entry[3:0], start_time[30:4],
                                                    // finish_time[57:31],
                                                    // elapsed_time[84:58]
   output logic                        rsp_tuser,   // kind[0]
   output logic                        rsp_tlast    // last
);

   // The controller sequences each request; the datapath holds all other state.
   cmd_type cmd;
   sts_type sts;

   rsft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath owns the clock, the tables and the response register.
   rsft_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // A response is loaded only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_ack || cmd.emit_entry) |-> (!rsp_tvalid || rsp_tready))
      else $error("response loaded over a pending response");

   // Finishes never run ahead of starts.
   assert property (@(posedge clock) disable iff (reset)
      sts.finished <= sts.started)
      else $error("finish count passed start count");

   // The start count never exceeds the table depth.
   assert property (@(posedge clock) disable iff (reset)
      sts.started <= ENTRY_W'(MAX_ENTRIES))
      else $error("start count beyond table depth");

   // A new request is taken only while no finish write or response load is being issued.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(cmd.fin_write || cmd.emit_ack || cmd.emit_entry))
      else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/rsft_ctrl.sv =====
//==============================================================================
// rsft_ctrl
// Sequencer of the timer: takes one request, decodes it and steps the datapath
// through ticking, stamping, clearing, finishing, acknowledging or the table dump.
//==============================================================================
`default_nettype none

module rsft_ctrl import rsft_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (sts.is_tick) begin
               cmd.tick = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.is_byte) begin
               cmd.byte_done = 1'b1;
               priority if (sts.is_start_cmd) begin
                  cmd.stamp_start = sts.can_start;
                  state_in        = ST_ACK;
               end else if (sts.is_ack_cmd) begin
                  state_in = ST_ACK;
               end else if (sts.is_read_cmd) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_DUMP_RD;
               end else begin
                  cmd.clear_slot = sts.clear_ok;
                  state_in       = ST_IDLE;
               end
            end else if (sts.is_finish && sts.can_finish) begin
               state_in = ST_FIN_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            cmd.fin_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_ACK: begin
            if (sts.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_dump = 1'b1;
            state_in    = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_dump = 1'b1;
            if (sts.out_free) begin
               cmd.emit_entry = 1'b1;
               if (sts.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/rsft_datapath.sv =====
//==============================================================================
// rsft_datapath
// Time-of-day clock, start and result tables, counters, elapsed-time
// arithmetic and the response register of the timer.
//==============================================================================
`default_nettype none

module rsft_datapath import rsft_pkg::*; #(
   parameter int MAX_ENTRIES = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [OP_W-1:0]        req_tuser,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RES_W = 2 * TIME_W;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

   localparam logic [BYTE_W-1:0] CH_START   = 8'h73;  // 's'
   localparam logic [BYTE_W-1:0] CH_CANCEL  = 8'h63;  // 'c'
   localparam logic [BYTE_W-1:0] CH_READ    = 8'h72;  // 'r'
   localparam logic [BYTE_W-1:0] CH_CONNECT = 8'h71;  // 'q'
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31;  // '1'
   localparam logic [BYTE_W-1:0] DIGIT_HI   = CH_ZERO + BYTE_W'(MAX_ENTRIES);

   localparam logic [MS_W-1:0]   MS_MAX      = 10'd999;
   localparam logic [MS_W-1:0]   MS_PER_SEC  = 10'd1000;
   localparam logic [SEC_W-1:0]  SEC_LAST    = 6'd59;
   localparam logic [SEC_W-1:0]  SEC_PER_MIN = 6'd60;
   localparam logic [MIN_W-1:0]  MIN_LAST    = 6'd59;
   localparam logic [MIN_W-1:0]  MIN_PER_HR  = 6'd60;
   localparam logic [HOUR_W-1:0] HOUR_LAST   = 5'd23;
   localparam logic [HOUR_W-1:0] HR_PER_DAY  = 5'd24;

   // Latched request
   logic [OP_W-1:0]   op_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [MS_W-1:0]   subsec_ff;

   // Control state
   logic [HOUR_W-1:0] hour_ff, hour_in;
   logic [MIN_W-1:0]  min_ff, min_in;
   logic [SEC_W-1:0]  sec_ff, sec_in;
   logic [CNT_W-1:0]  start_cnt_ff, start_cnt_in;
   logic [CNT_W-1:0]  fin_cnt_ff, fin_cnt_in;
   logic              on_track_ff, on_track_in;
   logic [BYTE_W-1:0] prev_byte_ff, prev_byte_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              start_vld_ff [MAX_ENTRIES];
   logic              res_vld_ff   [MAX_ENTRIES];

   // Tables: start stamps, and finish plus elapsed stamps of each slot
   logic [TIME_W-1:0] start_mem [MAX_ENTRIES];
   logic [RES_W-1:0]  res_mem   [MAX_ENTRIES];
   logic [TIME_W-1:0] rd_start_ff;
   logic [RES_W-1:0]  rd_res_ff;
   logic              rd_svld_ff;
   logic              rd_rvld_ff;
   logic [IDX_W-1:0]  rd_addr;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_kind_ff;
   logic                  rsp_last_ff;

   // Datapath signals
   logic [MS_W-1:0]   ms_sat;
   logic [TIME_W-1:0] now_time;
   logic [TIME_W-1:0] st_time;
   logic [TIME_W-1:0] rep_start, rep_finish, rep_elapsed;
   logic [TIME_W-1:0] elapsed;
   logic [MS_W-1:0]   el_ms;
   logic              ms_borrow;
   logic [SEC_W:0]    s_diff;
   logic [MIN_W:0]    m_diff;
   logic [HOUR_W:0]   h_diff;
   logic [SEC_W-1:0]  el_sec;
   logic [MIN_W-1:0]  el_min;
   logic [HOUR_W-1:0] el_hour;
   logic [IDX_W-1:0]  fin_idx, start_idx, clr_idx;
   logic [BYTE_W-1:0] clr_slot;
   logic              out_free;

   assign fin_idx   = fin_cnt_ff[IDX_W-1:0];
   assign start_idx = start_cnt_ff[IDX_W-1:0];
   assign clr_slot  = byte_ff - CH_ONE;
   assign clr_idx   = clr_slot[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Stamp of the current clock with the saturated millisecond count
   always_comb begin
      ms_sat   = (subsec_ff > MS_MAX) ? MS_MAX : subsec_ff;
      now_time = {hour_ff, min_ff, sec_ff, ms_sat};
   end

   // Elapsed time: field-wise subtract with borrows, hour wraps over midnight
   always_comb begin
      st_time   = rd_svld_ff ? rd_start_ff : '0;
      ms_borrow = now_time[MS_W-1:0] < st_time[MS_W-1:0];
      el_ms     = now_time[MS_W-1:0] - st_time[MS_W-1:0]
                  + (ms_borrow ? MS_PER_SEC : '0);
      s_diff    = {1'b0, now_time[15:10]} - {1'b0, st_time[15:10]}
                  - (SEC_W+1)'(ms_borrow);
      el_sec    = s_diff[SEC_W-1:0] + (s_diff[SEC_W] ? SEC_PER_MIN : '0);
      m_diff    = {1'b0, now_time[21:16]} - {1'b0, st_time[21:16]}
                  - (MIN_W+1)'(s_diff[SEC_W]);
      el_min    = m_diff[MIN_W-1:0] + (m_diff[MIN_W] ? MIN_PER_HR : '0);
      h_diff    = {1'b0, now_time[26:22]} - {1'b0, st_time[26:22]}
                  - (HOUR_W+1)'(m_diff[MIN_W]);
      if ($signed(h_diff) < -$signed((HOUR_W+1)'(HR_PER_DAY))) begin
         el_hour = h_diff[HOUR_W-1:0] + HR_PER_DAY + HR_PER_DAY;
      end else if (h_diff[HOUR_W]) begin
         el_hour = h_diff[HOUR_W-1:0] + HR_PER_DAY;
      end else begin
         el_hour = h_diff[HOUR_W-1:0];
      end
      elapsed = {el_hour, el_min, el_sec, el_ms};
   end

   // Next values of the control state
   always_comb begin
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      start_cnt_in = start_cnt_ff;
      fin_cnt_in   = fin_cnt_ff;
      on_track_in  = on_track_ff;
      prev_byte_in = prev_byte_ff;
      idx_in       = idx_ff;
      if (cmd.tick && on_track_ff) begin
         if (sec_ff == SEC_LAST) begin
            sec_in = '0;
            if (min_ff == MIN_LAST) begin
               min_in  = '0;
               hour_in = (hour_ff == HOUR_LAST) ? '0 : hour_ff + 1'b1;
            end else begin
               min_in = min_ff + 1'b1;
            end
         end else begin
            sec_in = sec_ff + 1'b1;
         end
      end
      if (cmd.byte_done) begin
         prev_byte_in = byte_ff;
      end
      if (cmd.stamp_start) begin
         start_cnt_in = start_cnt_ff + 1'b1;
         on_track_in  = 1'b1;
      end
      if (cmd.fin_write) begin
         fin_cnt_in = fin_cnt_ff + 1'b1;
         if (fin_cnt_in == start_cnt_ff) begin
            on_track_in = 1'b0;
         end
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= '0;
         min_ff       <= '0;
         sec_ff       <= '0;
         start_cnt_ff <= '0;
         fin_cnt_ff   <= '0;
         on_track_ff  <= 1'b0;
         prev_byte_ff <= '0;
         idx_ff       <= '0;
      end else begin
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         start_cnt_ff <= start_cnt_in;
         fin_cnt_ff   <= fin_cnt_in;
         on_track_ff  <= on_track_in;
         prev_byte_ff <= prev_byte_in;
         idx_ff       <= idx_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff     <= req_tuser;
         byte_ff   <= req_tdata[7:0];
         subsec_ff <= req_tdata[17:8];
      end
   end

   // Slot valid flags: an invalid slot reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            start_vld_ff[i] <= 1'b0;
            res_vld_ff[i]   <= 1'b0;
         end
      end else begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (cmd.stamp_start && start_idx == IDX_W'(i)) begin
               start_vld_ff[i] <= 1'b1;
            end
            if (cmd.fin_write && fin_idx == IDX_W'(i)) begin
               res_vld_ff[i] <= 1'b1;
            end
            if (cmd.clear_slot && clr_idx == IDX_W'(i)) begin
               start_vld_ff[i] <= 1'b0;
               res_vld_ff[i]   <= 1'b0;
            end
         end
      end
   end

   // Table writes and the single registered read port
   assign rd_addr = cmd.rd_dump ? idx_ff : fin_idx;

   always_ff @(posedge clock) begin
      if (cmd.stamp_start) begin
         start_mem[start_idx] <= now_time;
      end
      if (cmd.fin_write) begin
         res_mem[fin_idx] <= {elapsed, now_time};
      end
      if (cmd.rd_en) begin
         rd_start_ff <= start_mem[rd_addr];
         rd_res_ff   <= res_mem[rd_addr];
         rd_svld_ff  <= start_vld_ff[rd_addr];
         rd_rvld_ff  <= res_vld_ff[rd_addr];
      end
   end

   // Response register
   always_comb begin
      rep_start   = rd_svld_ff ? rd_start_ff : '0;
      rep_finish  = rd_rvld_ff ? rd_res_ff[TIME_W-1:0] : '0;
      rep_elapsed = rd_rvld_ff ? rd_res_ff[RES_W-1:TIME_W] : '0;
      if (cmd.emit_ack || cmd.emit_entry) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ack) begin
         rsp_data_ff <= '0;
         rsp_kind_ff <= KIND_ACK;
         rsp_last_ff <= 1'b1;
      end else if (cmd.emit_entry) begin
         rsp_data_ff <= {3'b000, rep_elapsed, rep_finish, rep_start,
                         ENTRY_W'(idx_ff)};
         rsp_kind_ff <= KIND_ENTRY;
         rsp_last_ff <= (idx_ff == IDX_LAST);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Status to the controller
   always_comb begin
      sts              = '0;
      sts.is_tick      = (op_ff == OP_TICK);
      sts.is_byte      = (op_ff == OP_BYTE);
      sts.is_finish    = (op_ff == OP_FINISH);
      sts.is_start_cmd = (byte_ff == CH_START);
      sts.is_ack_cmd   = (byte_ff == CH_CANCEL) || (byte_ff == CH_CONNECT);
      sts.is_read_cmd  = (byte_ff == CH_READ);
      sts.can_start    = (start_cnt_ff < CNT_MAX);
      sts.can_finish   = (fin_cnt_ff < start_cnt_ff) && (fin_cnt_ff < CNT_MAX);
      sts.clear_ok     = (prev_byte_ff == CH_CANCEL) && (byte_ff >= CH_ONE)
                         && (byte_ff <= DIGIT_HI);
      sts.idx_last     = (idx_ff == IDX_LAST);
      sts.out_free     = out_free;
      sts.started      = ENTRY_W'(start_cnt_ff);
      sts.finished     = ENTRY_W'(fin_cnt_ff);
   end

endmodule

`default_nettype wire
